>>> rtl/lvnd_pkg.sv
// ----------------------------------------------------------------------------
// lvnd_pkg: shared types and constants of the local variance noise detector
// Holds the frame size limits, the register index codes and the types that
// pass between the front end and the judging pipeline.
// ----------------------------------------------------------------------------
package lvnd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = COL_W + 1;
    localparam int HGT_W      = ROW_W + 1;
    localparam int TALLY_W    = 24;

    localparam logic [17:0] THRESH_RESET  = 18'd1000;
    localparam logic [6:0]  PERCENT_RESET = 7'd55;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_PERCENT   = 2'd1,
        REG_WIDTH     = 2'd2,
        REG_HEIGHT    = 2'd3
    } reg_index_t;

    // Which neighbourhoods the new pixel completes, with their clip.
    typedef struct packed {
        logic       valid;
        logic       judge_main;
        logic       judge_bottom;
        logic       judge_right;
        logic       judge_corner;
        logic       first_row;
        logic       first_col;
        logic       frame_end;
        logic [WID_W-1:0] live_w;
        logic [HGT_W-1:0] live_h;
    } step_ctrl_t;

    typedef logic [23:0] column_t;

endpackage

>>> rtl/local_variance_noise_detector.sv
// ----------------------------------------------------------------------------
// local_variance_noise_detector: 3x3 local variance noise detector
// Line stores, window and tally with a frame end result.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock in raster order and judges every pixel
// on its clipped 3x3 neighbourhood. Two line stores in one synchronous RAM
// (one read and one write per cycle, 16-bit words holding the two rows above)
// supply the older rows; a read at the store stage is written back one stage
// later, and since consecutive pixels hit different columns no forwarding is
// needed beyond a bypass for a one-column frame, which the clamp rules out.
// A pixel passes the store read stage, the window stage and a two-stage
// variance pipeline with four judging units, so one pixel is taken every
// cycle while the input does not stall, and the frame count and area are
// registered ahead of the queue. Results wait in a two-entry output queue
// (the output register and one spare register); the input stalls only on the
// last pixel of a frame, and only while two frame results are already in
// flight or waiting, so with a receiver that keeps up even the smallest
// frames stream without a gap. Geometry registers take effect at the first
// pixel of a frame.
// ----------------------------------------------------------------------------
module local_variance_noise_detector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data,
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [7:0]  pixel,
    output logic        valid_out,
    input  logic        ready_out,
    output logic [23:0] noisy_count,
    output logic        noise_detected
);
    import lvnd_pkg::*;

    logic [17:0] thresh_reg;
    logic [6:0]  percent_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RESET;
            percent_reg <= PERCENT_RESET;
            width_reg   <= 12'd2048;
            height_reg  <= 13'd4096;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_THRESHOLD: thresh_reg  <= cfg_data;
                REG_PERCENT:   percent_reg <= cfg_data[6:0];
                REG_WIDTH:     width_reg   <= cfg_data[11:0];
                REG_HEIGHT:    height_reg  <= cfg_data[12:0];
                default:       ;
            endcase
        end
    end

    // Position counters and frame geometry.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [WID_W-1:0] livew_reg, w_use;
    logic [HGT_W-1:0] liveh_reg, h_use;
    logic             accept;
    logic             first_pix;
    logic             last_col, last_row;
    logic             busy_end;

    assign first_pix = (col_reg == '0) && (row_reg == '0);

    always_comb
    begin
        if (width_reg < 12'd2)                w_use = WID_W'(2);
        else if (width_reg > 12'(MAX_WIDTH))  w_use = WID_W'(MAX_WIDTH);
        else                                  w_use = WID_W'(width_reg);
        if (height_reg < 13'd2)               h_use = HGT_W'(2);
        else if (height_reg > 13'(MAX_HEIGHT)) h_use = HGT_W'(MAX_HEIGHT);
        else                                  h_use = HGT_W'(height_reg);
        if (!first_pix)
        begin
            w_use = livew_reg;
            h_use = liveh_reg;
        end
    end

    assign last_col = ({1'b0, col_reg} == w_use - WID_W'(1));
    assign last_row = ({1'b0, row_reg} == h_use - HGT_W'(1));

    // Pipeline stage 1: store read issued, control registered.
    step_ctrl_t       s1_reg;
    logic [7:0]       s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [15:0]      line_mem [MAX_WIDTH];
    logic [15:0]      rd_reg;

    assign ready_in = !busy_end;
    assign accept   = valid_in && ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            livew_reg <= WID_W'(MAX_WIDTH);
            liveh_reg <= HGT_W'(MAX_HEIGHT);
            s1_reg    <= '0;
        end
        else
        begin
            s1_reg.valid <= accept;
            if (accept)
            begin
                livew_reg <= w_use;
                liveh_reg <= h_use;
                s1_reg.judge_main   <= (row_reg != '0) && (col_reg != '0);
                s1_reg.judge_bottom <= last_row && (col_reg != '0);
                s1_reg.judge_right  <= last_col && (row_reg != '0);
                s1_reg.judge_corner <= last_col && last_row;
                s1_reg.first_row    <= (row_reg == ROW_W'(1));
                s1_reg.first_col    <= (col_reg == COL_W'(1));
                s1_reg.frame_end    <= last_col && last_row;
                s1_reg.live_w       <= w_use;
                s1_reg.live_h       <= h_use;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel;
            s1_col_reg <= col_reg;
            rd_reg     <= line_mem[col_reg];
        end
        if (s1_reg.valid)
            line_mem[s1_col_reg] <= {s1_pix_reg, rd_reg[15:8]};
    end

    // Stage 2: window shift.
    column_t    win_reg [3];
    step_ctrl_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg     <= '0;
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else
        begin
            s2_reg <= s1_reg;
            if (s1_reg.valid)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= {s1_pix_reg, rd_reg[15:8], rd_reg[7:0]};
            end
        end
    end

    // Four judging units; the bottom and corner cases drop the top row of
    // the window, the right and corner cases drop its left column.
    logic [3:0] pv, pp;
    logic [3:0] jen;

    assign jen = {s2_reg.valid && s2_reg.judge_corner,
                  s2_reg.valid && s2_reg.judge_right,
                  s2_reg.valid && s2_reg.judge_bottom,
                  s2_reg.valid && s2_reg.judge_main};

    lvnd_judge u_main (.clk, .rst_n, .en(jen[0]), .win(win_reg),
        .skip_row(s2_reg.first_row), .skip_col(s2_reg.first_col),
        .threshold(thresh_reg), .pass_valid(pv[0]), .pass(pp[0]));
    lvnd_judge u_bottom (.clk, .rst_n, .en(jen[1]), .win(win_reg),
        .skip_row(1'b1), .skip_col(s2_reg.first_col),
        .threshold(thresh_reg), .pass_valid(pv[1]), .pass(pp[1]));
    lvnd_judge u_right (.clk, .rst_n, .en(jen[2]), .win(win_reg),
        .skip_row(s2_reg.first_row), .skip_col(1'b1),
        .threshold(thresh_reg), .pass_valid(pv[2]), .pass(pp[2]));
    lvnd_judge u_corner (.clk, .rst_n, .en(jen[3]), .win(win_reg),
        .skip_row(1'b1), .skip_col(1'b1),
        .threshold(thresh_reg), .pass_valid(pv[3]), .pass(pp[3]));

    // Delay frame end and geometry alongside the two judge stages.
    step_ctrl_t s3_reg, s4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else
        begin
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
        end
    end

    // Tally with saturation.
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [2:0]         hits;
    logic [TALLY_W:0]   sum;

    assign hits = 3'(pv[0] & pp[0]) + 3'(pv[1] & pp[1]) + 3'(pv[2] & pp[2])
                + 3'(pv[3] & pp[3]);
    assign sum  = {1'b0, tally_reg} + (TALLY_W+1)'(hits);
    assign tally_next = sum[TALLY_W] ? '1 : sum[TALLY_W-1:0];

    // Frame end: register count and area product, then compare.
    logic               fe_reg;
    logic [TALLY_W-1:0] fcount_reg;
    logic [WID_W+HGT_W-1:0] area_reg;
    logic [6:0]         fpct_reg;
    logic [30:0]        lim;
    logic [31:0]        cnt100;
    logic [WID_W+HGT_W+6:0] limit_full;
    logic               new_flag;

    // Output queue: the output register is the head, the spare register
    // holds a second result while the head waits for the receiver.
    logic               head_free;
    logic               spare_valid_reg;
    logic [TALLY_W-1:0] spare_count_reg;
    logic               spare_flag_reg;

    assign head_free = !valid_out || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg       <= '0;
            fe_reg          <= 1'b0;
            valid_out       <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            fe_reg <= s4_reg.valid && s4_reg.frame_end;
            if (s4_reg.valid && s4_reg.frame_end)
                tally_reg <= '0;
            else
                tally_reg <= tally_next;
            if (head_free)
            begin
                valid_out       <= spare_valid_reg || fe_reg;
                spare_valid_reg <= spare_valid_reg && fe_reg;
            end
            else if (fe_reg)
            begin
                spare_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_reg.valid && s4_reg.frame_end)
        begin
            fcount_reg <= tally_next;
            area_reg   <= s4_reg.live_w * s4_reg.live_h;
            fpct_reg   <= percent_reg;
        end
        if (head_free)
        begin
            if (spare_valid_reg)
            begin
                noisy_count    <= spare_count_reg;
                noise_detected <= spare_flag_reg;
            end
            else if (fe_reg)
            begin
                noisy_count    <= fcount_reg;
                noise_detected <= new_flag;
            end
        end
        if (fe_reg && (spare_valid_reg || !head_free))
        begin
            spare_count_reg <= fcount_reg;
            spare_flag_reg  <= new_flag;
        end
    end

    assign limit_full = fpct_reg * area_reg;
    assign lim        = 31'(limit_full);
    assign cnt100     = 32'(fcount_reg * 7'd100);
    assign new_flag   = (cnt100 > {1'b0, lim});

    // Frame results in flight from accept to the output queue, plus the ones
    // waiting there. A last pixel is taken only while a slot is left for it.
    logic [2:0] fe_pending;

    assign fe_pending = 3'(s1_reg.valid && s1_reg.frame_end)
                      + 3'(s2_reg.valid && s2_reg.frame_end)
                      + 3'(s3_reg.valid && s3_reg.frame_end)
                      + 3'(s4_reg.valid && s4_reg.frame_end)
                      + 3'(fe_reg) + 3'(valid_out) + 3'(spare_valid_reg);
    assign busy_end   = last_col && last_row && (fe_pending >= 3'd2);

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && !ready_out && !fe_reg |=> valid_out)
        else $error("result dropped while stalled");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fe_reg |-> !(valid_out && !ready_out && spare_valid_reg))
        else $error("frame result overwrote pending result");
    a_spare_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> valid_out)
        else $error("spare result without a head result");
    a_judge_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        jen[0] |=> ##1 pv[0])
        else $error("judge pipeline lost an item");

endmodule

>>> rtl/lvnd_judge.sv
// ----------------------------------------------------------------------------
// lvnd_judge: neighbourhood variance test
// Takes a 3x3 window and a clip, gives 1 when n*S2 - S1*S1 exceeds n*T.
// Pipelined in two register stages.
// ----------------------------------------------------------------------------
module lvnd_judge
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  lvnd_pkg::column_t      win [3],
    input  logic                   skip_row,
    input  logic                   skip_col,
    input  logic [17:0]            threshold,
    output logic                   pass_valid,
    output logic                   pass
);
    import lvnd_pkg::*;

    logic [3:0]  n_c;
    logic [11:0] s1_c;
    logic [19:0] s2_c;
    logic [3:0]  n_reg;
    logic [11:0] s1_reg;
    logic [19:0] s2_reg;
    logic [17:0] t_reg;
    logic        v1_reg;
    logic [23:0] lhs;
    logic [23:0] sq;
    logic [21:0] nt;

    always_comb
    begin
        logic [7:0] p;
        n_c  = '0;
        s1_c = '0;
        s2_c = '0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                p = win[k][8*i +: 8];
                if (!(skip_col && k == 0) && !(skip_row && i == 0)) begin
                    n_c  = n_c + 4'd1;
                    s1_c = s1_c + {4'd0, p};
                    s2_c = s2_c + {4'd0, 16'(p * p)};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            pass_valid <= 1'b0;
        end
        else
        begin
            v1_reg     <= en;
            pass_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg  <= n_c;
        s1_reg <= s1_c;
        s2_reg <= s2_c;
        t_reg  <= threshold;
    end

    assign lhs = 24'(n_reg * s2_reg);
    assign sq  = 24'(s1_reg * s1_reg);
    assign nt  = 22'(n_reg * t_reg);

    always_ff @(posedge clk)
    begin
        pass <= ({1'b0, lhs} > ({3'd0, nt} + {1'b0, sq}));
    end

endmodule

>>> verif/local_variance_noise_detector_test.sv
// ----------------------------------------------------------------------------
// local_variance_noise_detector_test: self-checking bench for the detector
// Streams small grey frames through the block under random sender bursts and
// receiver stalls, predicts each frame-end count and flag from its own model
// of the clipped 3x3 variance test, and compares every result in order.
// ----------------------------------------------------------------------------

// Holds the expected frame-end counts and flags and checks the block's results.
class frame_scoreboard;
    logic [23:0] count_q[$];
    logic        flag_q[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function void note_frame(logic [23:0] cnt, logic flag);
        count_q.push_back(cnt);
        flag_q.push_back(flag);
    endfunction

    function void check_result(logic [23:0] cnt, logic flag, longint t);
        logic [23:0] want_cnt;
        logic        want_flag;
        if (count_q.size() == 0)
        begin
            $display("%0t: unexpected result count=%0d flag=%0d", t, cnt, flag);
            errors++;
            return;
        end
        want_cnt  = count_q.pop_front();
        want_flag = flag_q.pop_front();
        if (cnt !== want_cnt)
        begin
            $display("%0t: noisy_count expected %0d actual %0d", t, want_cnt, cnt);
            errors++;
        end
        if (flag !== want_flag)
        begin
            $display("%0t: noise_detected expected %0d actual %0d", t, want_flag, flag);
            errors++;
        end
    endfunction

    function int pending();
        return count_q.size();
    endfunction
endclass

module local_variance_noise_detector_test;
    import lvnd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;
    logic        valid_in;
    logic        ready_in;
    logic [7:0]  pixel;
    logic        valid_out;
    logic        ready_out;
    logic [23:0] noisy_count;
    logic        noise_detected;

    local_variance_noise_detector DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .valid_in       (valid_in),
        .ready_in       (ready_in),
        .pixel          (pixel),
        .valid_out      (valid_out),
        .ready_out      (ready_out),
        .noisy_count    (noisy_count),
        .noise_detected (noise_detected)
    );

    // Predictor state: its own copy of the line stores, window and counters.
    logic [7:0]  older_line[MAX_WIDTH];
    logic [7:0]  prev_line[MAX_WIDTH];
    logic [23:0] win_col[3];
    int unsigned next_col, next_row, tally, cur_w, cur_h;
    int unsigned thresh_reg, percent_reg, width_reg, height_reg;

    frame_scoreboard sb;
    longint cycle_count;
    bit     hold_off;

    // Most pixels are drawn from one of these styles so both quiet and noisy
    // neighbourhoods show up often.
    int pixel_style;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Checks one neighbourhood made of window rows from top_row and columns
    // from left_col onward, both up to 2.
    function automatic void judge_window(int top_row, int left_col);
        longint unsigned n, s1, s2, p;
        n = 0;
        s1 = 0;
        s2 = 0;
        for (int k = left_col; k < 3; k++)
            for (int i = top_row; i < 3; i++)
            begin
                p = (win_col[k] >> (8 * i)) & 8'hFF;
                n++;
                s1 += p;
                s2 += p * p;
            end
        if (n * s2 > n * longint'(thresh_reg) + s1 * s1 && tally < 24'hFFFFFF)
            tally++;
    endfunction

    // Advances the predictor by one accepted pixel and notes any frame result.
    function automatic void predict_pixel(logic [7:0] pix);
        int unsigned c, r;
        logic [7:0]  top, mid;
        bit          last_col, last_row;
        longint unsigned lhs, rhs;
        if (next_col == 0 && next_row == 0)
        begin
            cur_w = clamp_size(width_reg, MAX_WIDTH);
            cur_h = clamp_size(height_reg, MAX_HEIGHT);
        end
        c = (next_col >= cur_w) ? cur_w - 1 : next_col;
        r = (next_row >= cur_h) ? cur_h - 1 : next_row;
        top = older_line[c];
        mid = prev_line[c];
        older_line[c] = mid;
        prev_line[c] = pix;
        win_col[0] = win_col[1];
        win_col[1] = win_col[2];
        win_col[2] = {pix, mid, top};
        last_col = (c == cur_w - 1);
        last_row = (r == cur_h - 1);
        // The centre pixel one row up and one column left is judged now; the
        // last row and last column are finished off when their final
        // neighbour comes in.
        if (r >= 1 && c >= 1)
            judge_window(r == 1 ? 1 : 0, c == 1 ? 1 : 0);
        if (last_row && c >= 1)
            judge_window(1, c == 1 ? 1 : 0);
        if (last_col && r >= 1)
            judge_window(r == 1 ? 1 : 0, 1);
        if (last_col && last_row)
            judge_window(1, 1);
        if (!last_col)
        begin
            next_col = c + 1;
            next_row = r;
            return;
        end
        next_col = 0;
        if (!last_row)
        begin
            next_row = r + 1;
            return;
        end
        next_row = 0;
        lhs = longint'(tally) * 100;
        rhs = longint'(percent_reg) * cur_w * cur_h;
        sb.note_frame(tally[23:0], lhs > rhs);
        tally = 0;
    endfunction

    // Register write, only issued while the block is idle.
    task automatic write_reg(reg_index_t idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[17:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD: thresh_reg  = value & 18'h3FFFF;
            REG_PERCENT:   percent_reg = value & 7'h7F;
            REG_WIDTH:     width_reg   = value & 12'hFFF;
            default:       height_reg  = value & 13'h1FFF;
        endcase
    endtask

    // Offers one pixel request and holds it until the block takes it.
    task automatic send_pixel(logic [7:0] pix);
        valid_in <= 1'b1;
        pixel    <= pix;
        @(posedge clk);
        while (!ready_in)
            @(posedge clk);
        predict_pixel(pix);
        @(negedge clk);
    endtask

    // Sender burst handling: after a burst, drop valid for a random gap.
    int burst_left;
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            valid_in <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [7:0] random_pixel();
        case (pixel_style)
            0: return 8'($urandom_range(0, 255));
            1: return 8'(100 + $urandom_range(0, 6));
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'd128;
        endcase
    endfunction

    // Sends one whole frame of the current geometry with random content.
    task automatic send_frame(int unsigned w, int unsigned h);
        for (int i = 0; i < w * h; i++)
        begin
            pace_sender();
            send_pixel(random_pixel());
        end
    endtask

    // Waits until every expected frame result has arrived, then lets the
    // pipeline drain before a register is touched.
    task automatic wait_idle();
        valid_in <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic run_phase(int unsigned thr, int unsigned pct, int unsigned w,
                             int unsigned h, int frames);
        wait_idle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_PERCENT, pct);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        for (int f = 0; f < frames; f++)
        begin
            pixel_style = $urandom_range(0, 3);
            send_frame(clamp_size(w, MAX_WIDTH), clamp_size(h, MAX_HEIGHT));
        end
    endtask

    // Receiver: stalls on its own random pattern, with one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            ready_out <= 1'b0;
        else if (cycle_count % 400 < 150)
            ready_out <= 1'b1;
        else
            ready_out <= ($urandom_range(0, 2) != 0);
    end

    // Results are sampled at the rising edge, after the handshake settles.
    always @(posedge clk)
    begin
        if (rst_n && valid_out && ready_out)
            sb.check_result(noisy_count, noise_detected, $time);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("[local_variance_noise_detector] ERROR");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        cycle_count = 0;
        hold_off = 0;
        burst_left = 0;
        pixel_style = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data = '0;
        valid_in = 1'b0;
        pixel = '0;
        ready_out = 1'b0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            older_line[i] = '0;
            prev_line[i] = '0;
        end
        win_col[0] = '0;
        win_col[1] = '0;
        win_col[2] = '0;
        next_col = 0;
        next_row = 0;
        tally = 0;
        thresh_reg = THRESH_RESET;
        percent_reg = PERCENT_RESET;
        width_reg = MAX_WIDTH;
        height_reg = MAX_HEIGHT;
        cur_w = MAX_WIDTH;
        cur_h = MAX_HEIGHT;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: the smallest frame with extreme pixels, threshold zero,
        // then a flat frame, a checkerboard at the largest threshold.
        wait_idle();
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_PERCENT, 0);
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        for (int i = 0; i < 4; i++)
            send_pixel(8'd77);
        wait_idle();
        // Out-of-range geometry is clamped to two; percent above 100 can
        // never flag.
        write_reg(REG_THRESHOLD, 18'h3FFFF);
        write_reg(REG_PERCENT, 127);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        // A 3x3 frame, with a threshold change in the middle of the frame
        // once the pixels already taken have left the pipeline.
        wait_idle();
        write_reg(REG_THRESHOLD, 500);
        write_reg(REG_PERCENT, 100);
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        for (int i = 0; i < 4; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0);
        valid_in <= 1'b0;
        repeat (10) @(negedge clk);
        write_reg(REG_THRESHOLD, 10);
        for (int i = 0; i < 5; i++)
            send_pixel(8'(i * 50));

        // Random phases over several settings, extremes included.
        run_phase(1000, 55, 5, 4, 6);
        run_phase(0, 0, 2, 7, 5);
        run_phase(262143, 100, 9, 2, 5);
        run_phase($urandom_range(0, 20000), $urandom_range(0, 100), 4, 4, 10);

        // Long receiver hold-off while frames keep coming, so the result
        // register fills and the input has to stall.
        wait_idle();
        write_reg(REG_THRESHOLD, $urandom_range(0, 3000));
        write_reg(REG_PERCENT, $urandom_range(0, 100));
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            for (int f = 0; f < 6; f++)
            begin
                pixel_style = $urandom_range(0, 3);
                send_frame(2, 2);
            end
        join

        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(0, 1) ? $urandom_range(0, 4000)
                                            : $urandom_range(0, 262143),
                      $urandom_range(0, 127), $urandom_range(2, 12),
                      $urandom_range(2, 10), 2);
        // One wide frame reaches well into the line stores.
        run_phase(2000, 50, 360, 2, 1);

        wait_idle();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[local_variance_noise_detector] OK");
        else
            $display("[local_variance_noise_detector] ERROR");
        $finish;
    end
endmodule

>>> files.f
rtl/lvnd_pkg.sv
rtl/lvnd_judge.sv
rtl/local_variance_noise_detector.sv
verif/local_variance_noise_detector_test.sv
